### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/tatd_pkg.sv
// ----------------------------------------------------------------------------
// Tilt angle detector package
// Widths, command codes, CORDIC constants and shared types.
// ----------------------------------------------------------------------------
package tatd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ACCEL_W         = 16;
  localparam int ANGLE_W         = 12;
  localparam int THRESH_W        = 8;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd15;

  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;

  localparam int CORDIC_STEPS  = 18;
  localparam int STEP_W        = $clog2(CORDIC_STEPS);
  localparam int NORM_BIT      = 40;
  localparam int COARSE_SHIFT  = 8;
  localparam int COARSE_BIT    = NORM_BIT - COARSE_SHIFT;
  localparam int XW            = NORM_BIT + 5;
  localparam int ZW            = 25;
  localparam int FRAC_SHIFT    = 12;

  localparam logic signed [ZW-1:0] DEG90      = 25'sd5898240;
  localparam logic signed [ZW-1:0] DEG180     = 25'sd11796480;
  localparam logic signed [ZW-1:0] ROUND_HALF = 25'sd2048;

  localparam logic [ANGLE_W-1:0] MAX_SIXTEENTHS = 12'd2880;

  // Arctangent of 2^-i in units of 2^-16 degree.
  localparam int ATAN_UNITS [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29
  };

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

### hw/rtl/tatd_if.sv
// ----------------------------------------------------------------------------
// Tilt angle detector channels
// Valid/ready channels for vectors, results and the threshold register.
// ----------------------------------------------------------------------------
interface tatd_in_if import tatd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [ACCEL_W-1:0] accel_x;
  logic signed [ACCEL_W-1:0] accel_y;
  logic signed [ACCEL_W-1:0] accel_z;

  modport source(output valid, command, accel_x, accel_y, accel_z, input ready);
  modport sink(input valid, command, accel_x, accel_y, accel_z, output ready);
endinterface

interface tatd_out_if import tatd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] tilt_angle;
  logic               over_threshold;
  logic               degenerate;

  modport source(output valid, tilt_angle, over_threshold, degenerate, input ready);
  modport sink(input valid, tilt_angle, over_threshold, degenerate, output ready);
endinterface

interface tatd_cfg_if import tatd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [THRESH_W-1:0] threshold_degrees;

  modport source(output valid, threshold_degrees, input ready);
  modport sink(input valid, threshold_degrees, output ready);
endinterface

### hw/rtl/tatd_sqrt.sv
// ----------------------------------------------------------------------------
// Iterative square root
// Bit-pair restoring root, two radicand bits per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module tatd_sqrt import tatd_pkg::*; #(
  parameter int IN_W = 4 * SAMPLE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [IN_W-1:0] radicand,
  output logic [IN_W/2:0] root,
  output sqrt_stat_t      stat
);

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_ITER = 3'b010,
    R_RND  = 3'b100
  } root_state_t;

  root_state_t     state;
  logic            done;
  logic [IN_W-1:0] rem;
  logic [IN_W-1:0] res;
  logic [IN_W-1:0] probe;
  logic [IN_W:0]   trial;

  assign trial = {1'b0, res} + {1'b0, probe};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        R_IDLE: begin
          if (start) begin
            rem   <= radicand;
            res   <= '0;
            probe <= {2'b01, {(IN_W-2){1'b0}}};
            state <= R_ITER;
          end
        end
        R_ITER: begin
          if ({1'b0, rem} >= trial) begin
            rem <= rem - trial[IN_W-1:0];
            res <= (res >> 1) + probe;
          end else begin
            res <= res >> 1;
          end
          probe <= probe >> 2;
          if (probe[0]) begin
            state <= R_RND;
          end
        end
        R_RND: begin
          // Round up when the remainder exceeds the root.
          root  <= res[IN_W/2:0] + (IN_W/2+1)'(rem > res);
          done  <= 1'b1;
          state <= R_IDLE;
        end
        default: state <= R_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != R_IDLE);
  assign stat.done = done;

endmodule

### hw/rtl/tilt_angle_threshold_detector.sv
// ----------------------------------------------------------------------------
// Tilt angle threshold detector
// Angle between a captured reference vector and new accelerometer vectors.
// ----------------------------------------------------------------------------
// One item is handled at a time. A capture, or a measure that finds a zero
// vector or no reference, passes from the accept state straight to the output
// state. A full measure runs the accept state, twelve products on the shared
// multiplier, the square root state, the normalize steps, 18 CORDIC rotations
// and the output state. The next item is taken while a result still waits.
`include "assert_macros.svh"

module tilt_angle_threshold_detector import tatd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  tatd_in_if.sink    request,
  tatd_out_if.source response,
  tatd_cfg_if.sink   cfg
);

  localparam int PW = 2 * SAMPLE_BITS;
  localparam int CW = PW + 1;
  localparam int DW = PW + 2;
  localparam int NW = 2 * PW;
  localparam int RW = NW / 2 + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ROOT = 6'b000100,
    S_NORM = 6'b001000,
    S_ROT  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    M_DOT_X, M_DOT_Y, M_DOT_Z,
    M_CX_A, M_CX_B, M_CY_A, M_CY_B, M_CZ_A, M_CZ_B,
    M_SQ_X, M_SQ_Y, M_SQ_Z
  } mul_step_t;

  state_t                    state;
  mul_step_t                 mstep;
  logic                      phase;
  logic [THRESH_W-1:0]       thr;
  logic signed [SAMPLE_BITS-1:0] ref_x, ref_y, ref_z;
  logic                      ref_valid;
  logic signed [SAMPLE_BITS-1:0] bx, by, bz;
  logic signed [SAMPLE_BITS-1:0] sx, sy, sz;
  logic                      sample_zero, ref_zero;
  logic signed [CW-1:0]      mul_a, mul_b;
  logic signed [2*CW-1:0]    prod;
  logic signed [PW-1:0]      p_lo;
  logic signed [PW-1:0]      tmp;
  logic signed [DW-1:0]      dot;
  logic [DW-1:0]             dot_mag;
  logic signed [CW-1:0]      cx, cy, cz;
  logic [NW-1:0]             nsum;
  logic                      sq_start;
  logic [RW-1:0]             sq_root;
  sqrt_stat_t                sq_stat;
  logic signed [XW-1:0]      x, y, xs, ys, mx;
  logic signed [ZW-1:0]      z, zc, zf, zsum;
  logic [STEP_W-1:0]         step;
  logic                      res_zero, res_deg;
  logic [ANGLE_W-1:0]        t_raw, t_cap;
  logic                      slot_free;
  logic                      out_valid;
  logic [ANGLE_W-1:0]        out_angle;
  logic                      out_over, out_deg;

  assign sx = request.accel_x[SAMPLE_BITS-1:0];
  assign sy = request.accel_y[SAMPLE_BITS-1:0];
  assign sz = request.accel_z[SAMPLE_BITS-1:0];
  assign sample_zero = (sx == '0) && (sy == '0) && (sz == '0);
  assign ref_zero    = (ref_x == '0) && (ref_y == '0) && (ref_z == '0);

  always_comb begin
    unique case (mstep)
      M_DOT_X: begin mul_a = CW'(ref_x); mul_b = CW'(bx); end
      M_DOT_Y: begin mul_a = CW'(ref_y); mul_b = CW'(by); end
      M_DOT_Z: begin mul_a = CW'(ref_z); mul_b = CW'(bz); end
      M_CX_A:  begin mul_a = CW'(ref_y); mul_b = CW'(bz); end
      M_CX_B:  begin mul_a = CW'(ref_z); mul_b = CW'(by); end
      M_CY_A:  begin mul_a = CW'(ref_z); mul_b = CW'(bx); end
      M_CY_B:  begin mul_a = CW'(ref_x); mul_b = CW'(bz); end
      M_CZ_A:  begin mul_a = CW'(ref_x); mul_b = CW'(by); end
      M_CZ_B:  begin mul_a = CW'(ref_y); mul_b = CW'(bx); end
      M_SQ_X:  begin mul_a = cx; mul_b = cx; end
      M_SQ_Y:  begin mul_a = cy; mul_b = cy; end
      M_SQ_Z:  begin mul_a = cz; mul_b = cz; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign p_lo    = prod[PW-1:0];
  assign dot_mag = dot[DW-1] ? DW'(-dot) : DW'(dot);

  assign sq_start = (state == S_ROOT) && !sq_stat.busy && !sq_stat.done;

  tatd_sqrt #(
    .IN_W(NW)
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .radicand(nsum),
    .root    (sq_root),
    .stat    (sq_stat)
  );

  assign mx = (x > y) ? x : y;
  assign xs = x >>> step;
  assign ys = y >>> step;

  // Clamp to the first quadrant, fold for an obtuse angle, round to 1/16 deg.
  always_comb begin
    if (z[ZW-1]) begin
      zc = '0;
    end else if (z > DEG90) begin
      zc = DEG90;
    end else begin
      zc = z;
    end
    zf    = dot[DW-1] ? DEG180 - zc : zc;
    zsum  = zf + ROUND_HALF;
    t_raw = zsum[ZW-2:FRAC_SHIFT];
    t_cap = (t_raw > MAX_SIXTEENTHS) ? MAX_SIXTEENTHS : t_raw;
  end

  assign slot_free = !out_valid || response.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ref_valid <= 1'b0;
      thr       <= THRESH_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        thr <= cfg.threshold_degrees;
      end
      if (out_valid && response.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (request.valid) begin
            bx <= sx;
            by <= sy;
            bz <= sz;
            if (request.command == CMD_CAPTURE) begin
              ref_x     <= sx;
              ref_y     <= sy;
              ref_z     <= sz;
              ref_valid <= 1'b1;
              res_zero  <= 1'b1;
              res_deg   <= sample_zero;
              state     <= S_FIN;
            end else if (!ref_valid || ref_zero || sample_zero) begin
              res_zero <= 1'b1;
              res_deg  <= 1'b1;
              state    <= S_FIN;
            end else begin
              res_zero <= 1'b0;
              res_deg  <= 1'b0;
              mstep    <= M_DOT_X;
              phase    <= 1'b0;
              state    <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (!phase) begin
            prod  <= mul_a * mul_b;
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            unique case (mstep) inside
              M_DOT_X:                  dot <= DW'(p_lo);
              M_DOT_Y, M_DOT_Z:         dot <= dot + DW'(p_lo);
              M_CX_A, M_CY_A, M_CZ_A:   tmp <= p_lo;
              M_CX_B:                   cx <= CW'(tmp) - CW'(p_lo);
              M_CY_B:                   cy <= CW'(tmp) - CW'(p_lo);
              M_CZ_B:                   cz <= CW'(tmp) - CW'(p_lo);
              M_SQ_X:                   nsum <= prod[NW-1:0];
              M_SQ_Y, M_SQ_Z:           nsum <= nsum + prod[NW-1:0];
              default:                  dot <= dot;
            endcase
            if (mstep == M_SQ_Z) begin
              state <= S_ROOT;
            end else begin
              mstep <= mul_step_t'(mstep + 4'd1);
            end
          end
        end
        S_ROOT: begin
          if (sq_stat.done) begin
            x     <= XW'(dot_mag);
            y     <= XW'(sq_root);
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // Scale both legs until the larger reaches the CORDIC working range.
          if (mx[XW-1:COARSE_BIT] == '0) begin
            x <= x <<< COARSE_SHIFT;
            y <= y <<< COARSE_SHIFT;
          end else if (mx[XW-1:NORM_BIT] == '0) begin
            x <= x <<< 1;
            y <= y <<< 1;
          end else begin
            z     <= '0;
            step  <= '0;
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (!y[XW-1]) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + ZW'(ATAN_UNITS[step]);
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - ZW'(ATAN_UNITS[step]);
          end
          if (step == STEP_W'(CORDIC_STEPS - 1)) begin
            state <= S_FIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_deg   <= res_deg;
            if (res_zero) begin
              out_angle <= '0;
              out_over  <= 1'b0;
            end else begin
              out_angle <= t_cap;
              out_over  <= (t_cap >= {thr, 4'b0000});
            end
            state <= S_IDLE;
          end else if (out_valid && response.ready) begin
            out_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign request.ready           = (state == S_IDLE);
  assign cfg.ready               = 1'b1;
  assign response.valid          = out_valid;
  assign response.tilt_angle     = out_angle;
  assign response.over_threshold = out_over;
  assign response.degenerate     = out_deg;

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, request.valid && request.ready, !request.ready, "input taken while an item is in flight")
  `ASSERT_IMPLIES(a_root_in_root_state, clk, rst, sq_stat.busy, state == S_ROOT, "square root unit running outside its state")
  `ASSERT_IMPLIES(a_degenerate_clean, clk, rst, response.valid && response.degenerate, response.tilt_angle == '0 && !response.over_threshold, "degenerate result carries an angle")
  `ASSERT_IMPLIES(a_angle_range, clk, rst, response.valid, response.tilt_angle <= MAX_SIXTEENTHS, "angle above 180 degrees")

endmodule
